// File: rtl/dgb_pkg.sv
// ----------------------------------------------------------------------------
// dgb_pkg
// Shared constants, operation codes and control/status types for the digit
// glyph blitter.
// ----------------------------------------------------------------------------
package dgb_pkg;

    // default geometry
    localparam int ROW_BYTES_DEF  = 16;
    localparam int FRAME_ROWS_DEF = 16;
    localparam int CELL_WIDTH_DEF = 6;
    localparam int GLYPH_ROWS_DEF = 10;
    localparam int GLYPH_TOP_DEF  = 5;

    // number of glyphs in the font store
    localparam int DIGITS = 10;

    // request field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 8;
    localparam int CELL_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int IN_DATA_W = 32;

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FONT   = 2'd0,
        OP_WRITE_FRAME = 2'd1,
        OP_DRAW        = 2'd2,
        OP_READ_FRAME  = 2'd3
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd0;
        logic wr0;
        logic rd1;
        logic wr1;
        logic load_res;
    } dgb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic row_last;
        logic out_free;
    } dgb_status_t;

endpackage

// File: rtl/dgb_ctrl.sv
// ----------------------------------------------------------------------------
// dgb_ctrl
// Sequencer for the blitter: reset clearing pass, request intake, the
// per-row read-modify-write of a draw, and result hand-off.
// ----------------------------------------------------------------------------
module dgb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  dgb_pkg::op_t        in_op,
    output logic                in_ready,
    input  dgb_pkg::dgb_status_t status,
    output dgb_pkg::dgb_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD0   = 7'b0000100,
        S_WR0   = 7'b0001000,
        S_RD1   = 7'b0010000,
        S_WR1   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_op == dgb_pkg::OP_DRAW)
                    begin
                        state_next = S_RD0;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = S_WR0;
            end
            S_WR0:
            begin
                cmd.wr0    = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr1 = 1'b1;
                if (status.row_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD0;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // a draw request starts its row sweep right away
    a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && in_op == dgb_pkg::OP_DRAW |=> state_reg == S_RD0)
        else $error("draw did not start row sweep");

    // the last row of a draw ends the sweep
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR1 && status.row_last |=> state_reg == S_FIN)
        else $error("row sweep ran past last row");

    // a result hand-off returns to intake
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && status.out_free |=> state_reg == S_IDLE)
        else $error("result hand-off did not return to idle");
`endif

endmodule

// File: rtl/dgb_datapath.sv
// ----------------------------------------------------------------------------
// dgb_datapath
// Frame and font memories, draw geometry registers, byte merge logic and
// the output result register.
// ----------------------------------------------------------------------------
module dgb_datapath #(
    parameter int ROW_BYTES  = dgb_pkg::ROW_BYTES_DEF,
    parameter int FRAME_ROWS = dgb_pkg::FRAME_ROWS_DEF,
    parameter int CELL_WIDTH = dgb_pkg::CELL_WIDTH_DEF,
    parameter int GLYPH_ROWS = dgb_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_TOP  = dgb_pkg::GLYPH_TOP_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dgb_pkg::dgb_cmd_t            cmd,
    output dgb_pkg::dgb_status_t         status,
    input  dgb_pkg::op_t                 in_op,
    input  logic [dgb_pkg::ADDR_W-1:0]   in_address,
    input  logic [dgb_pkg::DATA_W-1:0]   in_value,
    input  logic [dgb_pkg::CELL_W-1:0]   in_cell,
    input  logic [dgb_pkg::DIGIT_W-1:0]  in_digit,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [dgb_pkg::DATA_W-1:0]   out_read_data,
    output logic                         out_done
);

    localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS;
    localparam int FONT_BYTES  = dgb_pkg::DIGITS * GLYPH_ROWS;
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int FN_W        = $clog2(FONT_BYTES);
    localparam int ROW_W       = $clog2(FRAME_ROWS);
    localparam int BASE_W      = $clog2(((1 << dgb_pkg::CELL_W) - 1) * CELL_WIDTH + 1);
    localparam int BYTE_W      = BASE_W - 3;
    localparam logic [15:0] CLR_TOP = 16'(((1 << CELL_WIDTH) - 1) << (16 - CELL_WIDTH));

    // memories
    logic [dgb_pkg::DATA_W-1:0] frame_mem [FRAME_BYTES];
    logic [dgb_pkg::DATA_W-1:0] font_mem [FONT_BYTES];
    logic [dgb_pkg::DATA_W-1:0] frame_rdata_reg;
    logic [dgb_pkg::DATA_W-1:0] font_rdata_reg;

    // control registers
    logic [FA_W-1:0]            clr_cnt_reg;
    logic [FA_W-1:0]            clr_cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    // request and draw registers
    dgb_pkg::op_t               op_reg;
    logic                       rd_ok_reg;
    logic [BASE_W-1:0]          base_reg;
    logic                       glyph_en_reg;
    logic [FN_W-1:0]            font_base_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [FA_W-1:0]            row_base_reg;
    logic [dgb_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_done_reg;

    // combinational signals
    logic [BYTE_W-1:0]          byte0;
    logic [2:0]                 shift;
    logic                       byte0_ok;
    logic                       byte1_ok;
    logic [FA_W-1:0]            draw_addr0;
    logic [FA_W-1:0]            draw_addr1;
    logic                       glyph_row;
    logic [FN_W-1:0]            font_raddr;
    logic [15:0]                clr16;
    logic [15:0]                gly16;
    logic [dgb_pkg::DATA_W-1:0] new0;
    logic [dgb_pkg::DATA_W-1:0] new1;
    logic                       in_frame_ok;
    logic                       in_font_ok;
    logic                       fr_we;
    logic [FA_W-1:0]            fr_waddr;
    logic [dgb_pkg::DATA_W-1:0] fr_wdata;
    logic                       fr_re;
    logic [FA_W-1:0]            fr_raddr;
    logic                       font_we;
    logic [FN_W-1:0]            font_waddr;
    logic                       font_re;

    // draw geometry: two frame bytes per row starting at the cell column
    assign byte0      = base_reg[BASE_W-1:3];
    assign shift      = base_reg[2:0];
    assign byte0_ok   = 32'(byte0) < ROW_BYTES;
    assign byte1_ok   = (32'(byte0) + 32'd1) < ROW_BYTES;
    assign draw_addr0 = row_base_reg + FA_W'(byte0);
    assign draw_addr1 = draw_addr0 + FA_W'(1);
    assign glyph_row  = glyph_en_reg && (32'(row_reg) >= GLYPH_TOP)
                        && (32'(row_reg) < GLYPH_TOP + GLYPH_ROWS);
    assign font_raddr = font_base_reg + FN_W'(32'(row_reg) - 32'(GLYPH_TOP));

    // merge: clear the cell columns, then or in the glyph row
    assign clr16 = CLR_TOP >> shift;
    assign gly16 = glyph_row ? ({font_rdata_reg, 8'h00} >> shift) : 16'h0000;
    assign new0  = (frame_rdata_reg & ~clr16[15:8]) | gly16[15:8];
    assign new1  = (frame_rdata_reg & ~clr16[7:0]) | gly16[7:0];

    // request range checks
    assign in_frame_ok = 32'(in_address) < FRAME_BYTES;
    assign in_font_ok  = 32'(in_address) < FONT_BYTES;

    // memory port selection
    always_comb
    begin
        fr_we      = 1'b0;
        fr_waddr   = '0;
        fr_wdata   = '0;
        fr_re      = 1'b0;
        fr_raddr   = '0;
        font_we    = 1'b0;
        font_waddr = FN_W'(in_address);
        font_re    = 1'b0;
        priority if (cmd.clr_step)
        begin
            fr_we    = 1'b1;
            fr_waddr = clr_cnt_reg;
        end
        else if (cmd.accept)
        begin
            fr_we    = (in_op == dgb_pkg::OP_WRITE_FRAME) && in_frame_ok;
            fr_waddr = FA_W'(in_address);
            fr_wdata = in_value;
            fr_re    = (in_op == dgb_pkg::OP_READ_FRAME) && in_frame_ok;
            fr_raddr = FA_W'(in_address);
            font_we  = (in_op == dgb_pkg::OP_LOAD_FONT) && in_font_ok;
        end
        else if (cmd.rd0)
        begin
            fr_re    = byte0_ok;
            fr_raddr = draw_addr0;
            font_re  = glyph_row;
        end
        else if (cmd.wr0)
        begin
            fr_we    = byte0_ok;
            fr_waddr = draw_addr0;
            fr_wdata = new0;
        end
        else if (cmd.rd1)
        begin
            fr_re    = byte1_ok;
            fr_raddr = draw_addr1;
        end
        else if (cmd.wr1)
        begin
            fr_we    = byte1_ok;
            fr_waddr = draw_addr1;
            fr_wdata = new1;
        end
        else
        begin
            fr_re = 1'b0;
        end
    end

    // frame memory
    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            frame_mem[fr_waddr] <= fr_wdata;
        end
        if (fr_re)
        begin
            frame_rdata_reg <= frame_mem[fr_raddr];
        end
    end

    // font memory
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[font_waddr] <= in_value;
        end
        if (font_re)
        begin
            font_rdata_reg <= font_mem[font_raddr];
        end
    end

    // clearing counter and output valid
    always_comb
    begin
        clr_cnt_next = cmd.clr_step ? clr_cnt_reg + FA_W'(1) : clr_cnt_reg;
        priority if (cmd.load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture and row stepping
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= in_op;
            rd_ok_reg     <= in_frame_ok;
            base_reg      <= BASE_W'(32'(in_cell) * CELL_WIDTH);
            glyph_en_reg  <= 32'(in_digit) < dgb_pkg::DIGITS;
            font_base_reg <= FN_W'(32'(in_digit) * GLYPH_ROWS);
            row_reg       <= '0;
            row_base_reg  <= '0;
        end
        else if (cmd.wr1)
        begin
            row_reg      <= row_reg + ROW_W'(1);
            row_base_reg <= row_base_reg + FA_W'(ROW_BYTES);
        end
        if (cmd.load_res)
        begin
            out_data_reg <= (op_reg == dgb_pkg::OP_READ_FRAME && rd_ok_reg)
                            ? frame_rdata_reg : '0;
            out_done_reg <= 1'b1;
        end
    end

    // status and outputs
    assign status.clr_last = 32'(clr_cnt_reg) == FRAME_BYTES - 1;
    assign status.row_last = 32'(row_reg) == FRAME_ROWS - 1;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_read_data   = out_data_reg;
    assign out_done        = out_done_reg;

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    // frame writes stay inside the frame
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        fr_we |-> 32'(fr_waddr) < FRAME_BYTES)
        else $error("frame write out of range");

    // font writes stay inside the font store
    a_font_range: assert property (@(posedge clk) disable iff (!rst_n)
        font_we |-> 32'(font_waddr) < FONT_BYTES)
        else $error("font write out of range");
`endif

endmodule

// File: rtl/digit_glyph_blitter.sv
// ----------------------------------------------------------------------------
// digit_glyph_blitter
// One-bit-per-pixel framebuffer with a ten-digit font store; draws digit
// glyphs into fixed-width cells and serves byte reads and writes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind,
//   tdata carries address, value, cell and digit. Every request returns one
//   result on the m_axis channel: tdata is the frame byte for a read (zero
//   for other kinds), tuser is the done flag.
//   After reset the frame memory is swept to zero, byte by byte, with
//   s_axis_tready low. The font store is not cleared; load glyph rows
//   before drawing with them.
//   A load, write or read request goes from idle to the hand-off state,
//   which loads the result into the output register; the next request is
//   taken only once the sequencer is back in idle. A draw does a
//   read-modify-write of each of two frame bytes per row through the single
//   frame memory port, then hands its result off after the last row.
//   The result waits in an output register while m_axis_tready is low; one
//   more request is taken and finished meanwhile and held in the sequencer,
//   and no further request is taken until the waiting result moves out.
// ----------------------------------------------------------------------------
module digit_glyph_blitter #(
    parameter int ROW_BYTES  = dgb_pkg::ROW_BYTES_DEF,
    parameter int FRAME_ROWS = dgb_pkg::FRAME_ROWS_DEF,
    parameter int CELL_WIDTH = dgb_pkg::CELL_WIDTH_DEF,
    parameter int GLYPH_ROWS = dgb_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_TOP  = dgb_pkg::GLYPH_TOP_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address [7:0], value [15:8], cell_req [20:16], digit [24:21], zero pad
    input  logic [dgb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op [1:0]
    input  logic [dgb_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data [7:0]
    output logic [dgb_pkg::DATA_W-1:0]      m_axis_tdata,
    // done_res [0]
    output logic                            m_axis_tuser
);

    dgb_pkg::dgb_cmd_t    cmd;
    dgb_pkg::dgb_status_t status;
    dgb_pkg::op_t         in_op;

    // request field split
    assign in_op = dgb_pkg::op_t'(s_axis_tuser);

    // sequencer
    dgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (in_op),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // memories and merge logic
    dgb_datapath #(
        .ROW_BYTES  (ROW_BYTES),
        .FRAME_ROWS (FRAME_ROWS),
        .CELL_WIDTH (CELL_WIDTH),
        .GLYPH_ROWS (GLYPH_ROWS),
        .GLYPH_TOP  (GLYPH_TOP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_op         (in_op),
        .in_address    (s_axis_tdata[7:0]),
        .in_value      (s_axis_tdata[15:8]),
        .in_cell       (s_axis_tdata[20:16]),
        .in_digit      (s_axis_tdata[24:21]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_read_data (m_axis_tdata),
        .out_done      (m_axis_tuser)
    );

endmodule

// File: verif/tb_digit_glyph_blitter.sv
// ----------------------------------------------------------------------------
// tb_digit_glyph_blitter
// Self-checking bench for the digit glyph blitter: a shadow copy of the
// frame and font stores predicts every result, requests and result pickup
// are paced at random, and an output hold-off forces the block to stall.
// ----------------------------------------------------------------------------
module tb_digit_glyph_blitter;

    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the default build
    localparam int ROW_BYTES   = dgb_pkg::ROW_BYTES_DEF;
    localparam int FRAME_ROWS  = dgb_pkg::FRAME_ROWS_DEF;
    localparam int CELL_WIDTH  = dgb_pkg::CELL_WIDTH_DEF;
    localparam int GLYPH_ROWS  = dgb_pkg::GLYPH_ROWS_DEF;
    localparam int GLYPH_TOP   = dgb_pkg::GLYPH_TOP_DEF;
    localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS;
    localparam int FONT_BYTES  = dgb_pkg::DIGITS * GLYPH_ROWS;
    localparam int FRAME_COLS  = ROW_BYTES * 8;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 80;
    localparam int HOLD_STRETCH   = 150;
    localparam int RANDOM_ITEMS   = 1700;

    // request field types
    typedef logic [dgb_pkg::ADDR_W-1:0]  addr_t;
    typedef logic [dgb_pkg::DATA_W-1:0]  byte_t;
    typedef logic [dgb_pkg::CELL_W-1:0]  cell_pos_t;
    typedef logic [dgb_pkg::DIGIT_W-1:0] digit_t;

    typedef struct {
        logic [dgb_pkg::DATA_W-1:0] read_data;
        logic                       done;
    } readback_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [dgb_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [dgb_pkg::OP_W-1:0]      s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [dgb_pkg::DATA_W-1:0]    m_axis_tdata;
    logic                          m_axis_tuser;

    // shadow stores and results still owed by the block
    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] font_mem [FONT_BYTES];
    readback_t  readback_q [$];

    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    int hold_cycles  = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    digit_glyph_blitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // one pixel of the shadow frame, dropped when off the frame
    function automatic void set_pixel(int x, int y, bit lit);
        int idx;
        if (x >= FRAME_COLS || y >= FRAME_ROWS)
            return;
        idx = y * ROW_BYTES + x / 8;
        frame_mem[idx][7 - (x % 8)] = lit;
    endfunction

    // clear the cell in every row, then or in the glyph rows
    function automatic void draw_glyph(int cell_pos, int dig);
        int base;
        logic [7:0] row_bits;
        base = cell_pos * CELL_WIDTH;
        for (int r = 0; r < FRAME_ROWS; r++)
            for (int c = 0; c < CELL_WIDTH; c++)
                set_pixel(base + c, r, 1'b0);
        if (dig >= dgb_pkg::DIGITS)
            return;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            row_bits = font_mem[dig * GLYPH_ROWS + r];
            for (int c = 0; c < 8; c++)
                if (row_bits[7 - c])
                    set_pixel(base + c, GLYPH_TOP + r, 1'b1);
        end
    endfunction

    // update the shadow stores for one request and give its result
    function automatic readback_t apply_request(dgb_pkg::op_t op, addr_t addr, byte_t value,
                                                cell_pos_t cell_pos, digit_t dig);
        readback_t res;
        res.read_data = '0;
        res.done      = 1'b1;
        unique case (op)
            dgb_pkg::OP_LOAD_FONT:
                if (int'(addr) < FONT_BYTES)
                    font_mem[addr] = value;
            dgb_pkg::OP_WRITE_FRAME:
                if (int'(addr) < FRAME_BYTES)
                    frame_mem[addr] = value;
            dgb_pkg::OP_DRAW:
                draw_glyph(int'(cell_pos), int'(dig));
            default:
                if (int'(addr) < FRAME_BYTES)
                    res.read_data = frame_mem[addr];
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endtask

    // offer one request and book its result once taken
    task automatic send_request(dgb_pkg::op_t op, addr_t addr, byte_t value,
                                cell_pos_t cell_pos, digit_t dig);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, dig, cell_pos, value, addr};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        readback_q.push_back(apply_request(op, addr, value, cell_pos, dig));
    endtask

    // stop offering and wait for every booked result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (readback_q.size() != 0)
            @(posedge clk);
    endtask

    // one request of a random kind; every digit's font is loaded by now
    task automatic random_request();
        int pick;
        cell_pos_t cell_pos;
        digit_t dig;
        pick     = $urandom_range(0, 99);
        cell_pos = cell_pos_t'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 20)
                                                            : $urandom_range(21, 31));
        dig      = digit_t'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 9)
                                                         : $urandom_range(10, 15));
        if (pick < 15)
            send_request(dgb_pkg::OP_LOAD_FONT,
                         addr_t'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 255)
                                                             : $urandom_range(0, 99)),
                         byte_t'($urandom_range(0, 255)), cell_pos_t'($urandom()),
                         digit_t'($urandom()));
        else if (pick < 40)
            send_request(dgb_pkg::OP_WRITE_FRAME, addr_t'($urandom_range(0, 255)),
                         byte_t'($urandom_range(0, 255)), cell_pos_t'($urandom()),
                         digit_t'($urandom()));
        else if (pick < 65)
            send_request(dgb_pkg::OP_DRAW, addr_t'($urandom()), byte_t'($urandom()),
                         cell_pos, dig);
        else
            send_request(dgb_pkg::OP_READ_FRAME, addr_t'($urandom_range(0, 255)),
                         byte_t'($urandom()), cell_pos_t'($urandom()), digit_t'($urandom()));
    endtask

    // byte access at the address extremes, including the cleared state
    task automatic test_frame_bytes();
        send_request(dgb_pkg::OP_READ_FRAME, 8'd0, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd255, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_WRITE_FRAME, 8'd0, 8'hFF, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_WRITE_FRAME, 8'd255, 8'hA5, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd0, 8'hFF, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd255, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_WRITE_FRAME, 8'd255, 8'h00, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd255, 8'd0, 5'd0, 4'd0);
        drain_results();
    endtask

    // fill the whole font; loads past its end must be dropped
    task automatic test_font_load();
        for (int a = 0; a < FONT_BYTES; a++)
        begin
            send_request(dgb_pkg::OP_LOAD_FONT, addr_t'(a), byte_t'($urandom_range(0, 255)),
                         cell_pos_t'($urandom()), digit_t'($urandom()));
            if (a == 37)
                send_request(dgb_pkg::OP_LOAD_FONT, 8'd100, 8'hFF, 5'd0, 4'd0);
        end
        send_request(dgb_pkg::OP_LOAD_FONT, 8'd255, 8'hFF, 5'd31, 4'd15);
        drain_results();
    endtask

    // cell clearing, spill into the next cell, right edge and bad digits
    task automatic test_draw_cases();
        send_request(dgb_pkg::OP_WRITE_FRAME, 8'd240, 8'hFF, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd0, 4'd8);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd0, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd240, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd80, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd1, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd80, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd225, 8'd0, 5'd0, 4'd0);
        // last cell that fits, then cells running off the right edge
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd20, 4'd9);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd95, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd239, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd21, 4'd5);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd111, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd31, 4'd3);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd95, 8'd0, 5'd0, 4'd0);
        // digits past nine only clear the cell
        send_request(dgb_pkg::OP_WRITE_FRAME, 8'd82, 8'hFF, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd2, 4'd15);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd81, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd82, 8'd0, 5'd0, 4'd0);
        send_request(dgb_pkg::OP_DRAW, 8'd0, 8'd0, 5'd3, 4'd10);
        send_request(dgb_pkg::OP_READ_FRAME, 8'd82, 8'd0, 5'd0, 4'd0);
        drain_results();
    endtask

    // long output hold-off while requests keep coming
    task automatic test_output_hold();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_cycles  = HOLD_STRETCH;
        repeat (30) random_request();
        drain_results();
    endtask

    // random traffic in stretches with different pacing on each side
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
            begin
                unique case ((i / 200) % 4)
                    0:
                    begin
                        src_idle_en  = 1'b1;
                        sink_idle_en = 1'b1;
                    end
                    1:
                    begin
                        src_idle_en  = 1'b0;
                        sink_idle_en = 1'b0;
                    end
                    2:
                    begin
                        src_idle_en  = 1'b1;
                        sink_idle_en = 1'b0;
                    end
                    default:
                    begin
                        src_idle_en  = 1'b0;
                        sink_idle_en = 1'b1;
                    end
                endcase
            end
            random_request();
        end
        drain_results();
    endtask

    // result pickup pacing, with the long hold-off on request
    initial
    begin : sink_pacing
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                wait_left = sink_idle_en ? $urandom_range(0, 4) : 0;
            else if (!m_axis_tready && wait_left > 0)
                wait_left--;
            if (hold_cycles > 0)
            begin
                wait_left   = hold_cycles;
                hold_cycles = 0;
            end
            m_axis_tready <= (wait_left == 0);
        end
    end

    // compare each result with the oldest booked one
    always @(posedge clk)
    begin : check_results
        readback_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (readback_q.size() == 0)
                note_mismatch("unbooked result, read_data", 0, int'(m_axis_tdata));
            else
            begin
                want = readback_q.pop_front();
                if (m_axis_tdata !== want.read_data)
                    note_mismatch("read_data", int'(want.read_data), int'(m_axis_tdata));
                if (m_axis_tuser !== want.done)
                    note_mismatch("done_res", int'(want.done), int'(m_axis_tuser));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("digit_glyph_blitter: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // test sequence
    initial
    begin
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        foreach (font_mem[i])
            font_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_frame_bytes();
        test_font_load();
        test_draw_cases();
        test_output_hold();
        test_random(RANDOM_ITEMS);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && readback_q.size() == 0)
            $display("digit_glyph_blitter: match");
        else
            $display("digit_glyph_blitter: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dgb_pkg.sv
rtl/dgb_ctrl.sv
rtl/dgb_datapath.sv
rtl/digit_glyph_blitter.sv
verif/tb_digit_glyph_blitter.sv
